@@ rtl/sptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// sptrs_pkg
// Shared sizes, codes and interface structs of the sparse table range spread
// block.
// ----------------------------------------------------------------------------
package sptrs_pkg;

    localparam int DEPTH      = 1024;
    localparam int LEVELS     = 11;
    localparam int VALUE_BITS = 20;

    // field widths of the command and result items
    localparam int CMD_BITS    = 2;
    localparam int SAMPLE_BITS = 20;
    localparam int INDEX_BITS  = 10;
    localparam int SPREAD_BITS = 20;
    localparam int STATUS_BITS = 2;

    localparam int IDX_BITS      = $clog2(DEPTH);
    localparam int CNT_BITS      = $clog2(DEPTH + 1);
    localparam int LVL_BITS      = $clog2(LEVELS);
    localparam int TBL_DEPTH     = LEVELS * DEPTH;
    localparam int TBL_ADDR_BITS = $clog2(TBL_DEPTH);
    localparam int LEN_BITS      = INDEX_BITS + 1;
    localparam int CMP_BITS      = (INDEX_BITS > CNT_BITS) ? INDEX_BITS : CNT_BITS;
    localparam int SPAN_BITS     = ((LEVELS > CNT_BITS) ? LEVELS : CNT_BITS) + 1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_RANGE = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_QADDR,
        S_QMIN,
        S_QSUB
    } state_t;

    typedef struct packed {
        logic                     en;
        logic [TBL_ADDR_BITS-1:0] addr;
        logic [VALUE_BITS-1:0]    min_val;
        logic [VALUE_BITS-1:0]    max_val;
    } tbl_wr_t;

    typedef struct packed {
        logic [TBL_ADDR_BITS-1:0] addr_a;
        logic [TBL_ADDR_BITS-1:0] addr_b;
    } tbl_rd_req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] min_a;
        logic [VALUE_BITS-1:0] max_a;
        logic [VALUE_BITS-1:0] min_b;
        logic [VALUE_BITS-1:0] max_b;
    } tbl_rd_data_t;

endpackage

@@ rtl/sparse_table_range_spread.sv @@
// ----------------------------------------------------------------------------
// sparse_table_range_spread
// Range spread (max minus min) over appended values, kept in a sparse table.
// ----------------------------------------------------------------------------
// Usage:
//   A command item (cmd, sample, left_index, right_index) is taken at a
//   clock edge with start high and busy low. busy stays high while the
//   item is worked on. A result item (spread, status) is shown for one
//   cycle with done high; the receiver cannot stall it.
//   Clear and the unused code give no result and leave busy low.
//   Append at index p writes one table level per cycle, levels
//   floor(log2(p+1))+1 (at most LEVELS = 11), all through one min/max
//   compare unit and one table read port. Append to a full store and
//   a query out of range answer without raising busy.
//   A valid query reads both windows together, compares, then subtracts.
//   busy drops in the cycle done shows, so the next item may follow.
//   Reset clears the stored count and the control state; table contents
//   are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module sparse_table_range_spread (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sptrs_pkg::CMD_BITS-1:0]    cmd,
    input  logic [sptrs_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [sptrs_pkg::INDEX_BITS-1:0]  left_index,
    input  logic [sptrs_pkg::INDEX_BITS-1:0]  right_index,
    output logic                              busy,
    output logic                              done,
    output logic [sptrs_pkg::SPREAD_BITS-1:0] spread,
    output logic [sptrs_pkg::STATUS_BITS-1:0] status
);
    import sptrs_pkg::*;

    function automatic logic [TBL_ADDR_BITS-1:0] tbl_addr(
        input logic [LVL_BITS-1:0] lvl,
        input logic [IDX_BITS-1:0] idx
    );
        return TBL_ADDR_BITS'(TBL_ADDR_BITS'(lvl) * TBL_ADDR_BITS'(DEPTH))
               + TBL_ADDR_BITS'(idx);
    endfunction

    // highest set bit of the length, clamped to the top table level
    function automatic logic [LVL_BITS-1:0] level_of(input logic [LEN_BITS-1:0] len);
        int k;
        k = 0;
        for (int i = 1; i < LEN_BITS; i++)
        begin
            if (len[i])
            begin
                k = i;
            end
        end
        if (k > LEVELS - 1)
        begin
            k = LEVELS - 1;
        end
        return LVL_BITS'(k);
    endfunction

    state_t                  state_reg, state_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic [LVL_BITS-1:0]     lvl_reg, lvl_next;
    logic [VALUE_BITS-1:0]   sample_reg, sample_next;
    logic [INDEX_BITS-1:0]   left_reg, left_next;
    logic [INDEX_BITS-1:0]   right_reg, right_next;
    logic [VALUE_BITS-1:0]   prev_min_reg, prev_min_next;
    logic [VALUE_BITS-1:0]   prev_max_reg, prev_max_next;
    logic [VALUE_BITS-1:0]   qmin_reg, qmin_next;
    logic [VALUE_BITS-1:0]   qmax_reg, qmax_next;
    logic                    done_reg, done_next;
    logic [SPREAD_BITS-1:0]  spread_reg, spread_next;
    logic [STATUS_BITS-1:0]  status_reg, status_next;

    tbl_wr_t      tbl_wr;
    tbl_rd_req_t  tbl_req;
    tbl_rd_data_t tbl_rd;

    // shared compare unit
    logic [VALUE_BITS-1:0] op_min_b, op_max_b;
    logic [VALUE_BITS-1:0] unit_min, unit_max;

    logic                  accept;
    logic                  bad_range;
    logic [SPAN_BITS-1:0]  pos_plus1;
    logic [SPAN_BITS-1:0]  cur_pow, nxt_pow;
    logic [SPAN_BITS-1:0]  cur_start, nxt_start;
    logic                  more_levels;
    logic [LEN_BITS-1:0]   q_len;
    logic [LVL_BITS-1:0]   q_lvl;
    logic [LEN_BITS-1:0]   q_second;

    sptrs_tables u_tables (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_req  (tbl_req),
        .rd_data (tbl_rd)
    );

    assign accept = start && (state_reg == S_IDLE);

    assign op_min_b = (state_reg == S_FILL) ? prev_min_reg : tbl_rd.min_b;
    assign op_max_b = (state_reg == S_FILL) ? prev_max_reg : tbl_rd.max_b;
    assign unit_min = (tbl_rd.min_a < op_min_b) ? tbl_rd.min_a : op_min_b;
    assign unit_max = (tbl_rd.max_a > op_max_b) ? tbl_rd.max_a : op_max_b;

    assign bad_range = (left_index > right_index)
                       || (CMP_BITS'(right_index) >= CMP_BITS'(count_reg));

    // windows that end at the new index: start = p + 1 - 2^level
    assign pos_plus1   = SPAN_BITS'(count_reg) + SPAN_BITS'(1);
    assign cur_pow     = SPAN_BITS'(1) << lvl_reg;
    assign nxt_pow     = SPAN_BITS'(1) << ({1'b0, lvl_reg} + (LVL_BITS + 1)'(1));
    assign cur_start   = pos_plus1 - cur_pow;
    assign nxt_start   = pos_plus1 - nxt_pow;
    assign more_levels = ((int'(lvl_reg) + 1) < LEVELS) && (nxt_pow <= pos_plus1);

    assign q_len    = LEN_BITS'(right_reg) - LEN_BITS'(left_reg) + LEN_BITS'(1);
    assign q_lvl    = level_of(q_len);
    assign q_second = LEN_BITS'(right_reg) + LEN_BITS'(1) - (LEN_BITS'(1) << q_lvl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        sample_reg   <= sample_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        prev_min_reg <= prev_min_next;
        prev_max_reg <= prev_max_next;
        qmin_reg     <= qmin_next;
        qmax_reg     <= qmax_next;
        spread_reg   <= spread_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lvl_next      = lvl_reg;
        sample_next   = sample_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        prev_min_next = prev_min_reg;
        prev_max_next = prev_max_reg;
        qmin_next     = qmin_reg;
        qmax_next     = qmax_reg;
        done_next     = 1'b0;
        spread_next   = spread_reg;
        status_next   = status_reg;
        tbl_wr        = '0;
        tbl_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = VALUE_BITS'(sample);
                    left_next   = left_index;
                    right_next  = right_index;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg >= CNT_BITS'(DEPTH))
                            begin
                                done_next   = 1'b1;
                                spread_next = '0;
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                lvl_next   = '0;
                                state_next = S_FILL;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (bad_range)
                            begin
                                done_next   = 1'b1;
                                spread_next = '0;
                                status_next = STAT_BAD_RANGE;
                            end
                            else
                            begin
                                state_next = S_QADDR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                // level 0 takes the sample; higher levels merge the window read
                // last cycle with the one written last cycle
                tbl_wr.en      = 1'b1;
                tbl_wr.addr    = tbl_addr(lvl_reg, cur_start[IDX_BITS-1:0]);
                tbl_wr.min_val = (lvl_reg == '0) ? sample_reg : unit_min;
                tbl_wr.max_val = (lvl_reg == '0) ? sample_reg : unit_max;
                prev_min_next  = tbl_wr.min_val;
                prev_max_next  = tbl_wr.max_val;
                if (more_levels)
                begin
                    tbl_req.addr_a = tbl_addr(lvl_reg, nxt_start[IDX_BITS-1:0]);
                    lvl_next       = lvl_reg + LVL_BITS'(1);
                end
                else
                begin
                    count_next  = count_reg + CNT_BITS'(1);
                    done_next   = 1'b1;
                    spread_next = '0;
                    status_next = STAT_OK;
                    state_next  = S_IDLE;
                end
            end
            S_QADDR:
            begin
                tbl_req.addr_a = tbl_addr(q_lvl, IDX_BITS'(left_reg));
                tbl_req.addr_b = tbl_addr(q_lvl, IDX_BITS'(q_second));
                state_next     = S_QMIN;
            end
            S_QMIN:
            begin
                qmin_next  = unit_min;
                qmax_next  = unit_max;
                state_next = S_QSUB;
            end
            S_QSUB:
            begin
                done_next   = 1'b1;
                spread_next = SPREAD_BITS'(qmax_reg - qmin_reg);
                status_next = STAT_OK;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign spread = spread_reg;
    assign status = status_reg;

endmodule

@@ rtl/sptrs_tables.sv @@
// ----------------------------------------------------------------------------
// sptrs_tables
// Window minimum and maximum tables: one write port, two registered read
// ports, both tables addressed together.
// ----------------------------------------------------------------------------
module sptrs_tables (
    input  logic                   clk,
    input  sptrs_pkg::tbl_wr_t      wr,
    input  sptrs_pkg::tbl_rd_req_t  rd_req,
    output sptrs_pkg::tbl_rd_data_t rd_data
);
    import sptrs_pkg::*;

    logic [VALUE_BITS-1:0] min_mem [TBL_DEPTH];
    logic [VALUE_BITS-1:0] max_mem [TBL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            min_mem[wr.addr] <= wr.min_val;
            max_mem[wr.addr] <= wr.max_val;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data.min_a <= min_mem[rd_req.addr_a];
        rd_data.max_a <= max_mem[rd_req.addr_a];
        rd_data.min_b <= min_mem[rd_req.addr_b];
        rd_data.max_b <= max_mem[rd_req.addr_b];
    end

endmodule

@@ rtl/sptrs_checker.sv @@
// ----------------------------------------------------------------------------
// sptrs_checker
// Port-level checks of the sparse table range spread block, bound to the top.
// ----------------------------------------------------------------------------
module sptrs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic [sptrs_pkg::CMD_BITS-1:0]    cmd,
    input logic [sptrs_pkg::INDEX_BITS-1:0]  left_index,
    input logic [sptrs_pkg::INDEX_BITS-1:0]  right_index,
    input logic                              busy,
    input logic                              done,
    input logic [sptrs_pkg::SPREAD_BITS-1:0] spread,
    input logic [sptrs_pkg::STATUS_BITS-1:0] status
);
    import sptrs_pkg::*;

    logic take;
    assign take = start && !busy;

    // clear and the unused code make no item
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && (cmd != CMD_APPEND) && (cmd != CMD_QUERY) |=> !done)
        else $error("result item after clear or unused command");

    a_bad_range: assert property (@(posedge clk) disable iff (!rst_n)
        take && (cmd == CMD_QUERY) && (left_index > right_index)
        |=> done && (status == STAT_BAD_RANGE) && (spread == '0))
        else $error("reversed range not answered as bad range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STAT_OK) |-> (spread == '0))
        else $error("nonzero spread on an error status");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        take && (cmd == CMD_APPEND) |=> busy || (done && (status == STAT_FULL)))
        else $error("append neither filled nor rejected as full");

endmodule

bind sparse_table_range_spread sptrs_checker u_sptrs_checker (.*);
